FILE: design/nat_pkg.sv
// Shared types, constants and helpers for the NAT session table.
package nat_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
   localparam int ADDR_W        = SLOT_W + 1;
   localparam int DEPTH         = 2 * TABLE_ENTRIES;
   localparam int SLOT_INDEX_W  = 6;

   localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(TABLE_ENTRIES - 1);
   localparam logic [SLOT_W-1:0] FIRST_SLOT = '0;

   localparam logic [1:0] OP_OUTBOUND = 2'd0;
   localparam logic [1:0] OP_INBOUND  = 2'd1;
   localparam logic [1:0] OP_INSERT   = 2'd2;

   typedef struct packed {
      logic [1:0]  opcode;
      logic        table_select;
      logic [31:0] remote_ip;
      logic [15:0] remote_port;
      logic [31:0] local_ip;
      logic [15:0] local_port;
      logic [31:0] public_ip;
      logic [15:0] public_port;
      logic [31:0] expire_time;
   } req_type;

   typedef struct packed {
      logic                    found;
      logic [SLOT_INDEX_W-1:0] slot_index;
      logic                    evicted;
      logic [31:0]             entry_remote_ip;
      logic [15:0]             entry_remote_port;
      logic [31:0]             entry_local_ip;
      logic [15:0]             entry_local_port;
      logic [31:0]             entry_public_ip;
      logic [15:0]             entry_public_port;
      logic [31:0]             entry_expiry;
   } rsp_type;

   typedef struct packed {
      logic [31:0] remote_ip;
      logic [15:0] remote_port;
      logic [31:0] local_ip;
      logic [15:0] local_port;
      logic [31:0] public_ip;
      logic [15:0] public_port;
      logic [31:0] expiry;
   } entry_type;

   // Result of checking one stored entry against the request.
   typedef struct packed {
      logic hit;
      logic empty;
      logic less;
   } scan_type;

   // Slot number as reported on the result, taken modulo 64.
   function automatic logic [SLOT_INDEX_W-1:0] slot_to_index(input logic [SLOT_W-1:0] slot);
      logic [SLOT_W+SLOT_INDEX_W-1:0] ext;
      ext = {{SLOT_INDEX_W{1'b0}}, slot};
      return ext[SLOT_INDEX_W-1:0];
   endfunction

endpackage

FILE: design/nat_chan_if.sv
// Valid/ready channel interfaces for requests and results.
interface nat_req_if import nat_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface nat_rsp_if import nat_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: design/nat_scan_unit.sv
// Shared compare unit: matches one stored entry against the request keys.
module nat_scan_unit import nat_pkg::*; (
   input  entry_type   entry,
   input  req_type     key,
   input  logic [31:0] min_expiry,
   output scan_type    result
);

   logic remote_match;
   logic side_match;

   assign remote_match = (entry.remote_ip == key.remote_ip) &&
                         (entry.remote_port == key.remote_port);

   // Outbound keys on the inside host, inbound on the public address.
   assign side_match = (key.opcode == OP_OUTBOUND) ?
      ((entry.local_ip == key.local_ip) && (entry.local_port == key.local_port)) :
      ((entry.public_ip == key.public_ip) && (entry.public_port == key.public_port));

   assign result.hit   = remote_match && side_match;
   assign result.empty = (entry.remote_ip == 32'd0);
   assign result.less  = (entry.expiry < min_expiry);

endmodule

FILE: design/nat_session_table.sv
// NAT session table top level: TCP and UDP tables scanned one slot a cycle.
//
// Two session tables (TCP and UDP) of TABLE_ENTRIES slots each share one
// memory; both are empty after reset, tracked by one valid bit per slot so no
// clearing pass is needed. One request is handled at a time: req_chan.ready is
// high only while the block is idle. Every lookup or insert walks the selected
// table from slot 0 upward, one slot per cycle through the registered memory
// read port and a single shared compare unit. A lookup stops at the first slot
// that hits and presents that slot's entry; a miss scans the whole table and
// presents an all-zero result. An insert stops at the first slot with a zero
// remote address, or scans the whole table while tracking the smallest expiry
// and evicts the first slot holding it, then writes the entry in a write state.
// The result is held in an output register until the rsp_chan transfer; the
// block returns to idle on the cycle after that transfer and then takes the next
// request. An unknown opcode presents an all-zero result in the cycle right after
// its transfer and changes nothing.
module nat_session_table import nat_pkg::*; (
   input logic        clock,
   input logic        reset,
   nat_req_if.sink    req_chan,
   nat_rsp_if.source  rsp_chan
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_WRITE = 2'd2;
   localparam logic [1:0] ST_RESP  = 2'd3;

   logic [1:0]        state_ff, state_in;
   req_type           req_ff, req_in;
   logic [SLOT_W-1:0] cnt_ff, cnt_in;
   logic              issue_done_ff, issue_done_in;
   logic              chk_valid_ff, chk_valid_in;
   logic [SLOT_W-1:0] chk_idx_ff, chk_idx_in;
   logic [SLOT_W-1:0] victim_ff, victim_in;
   logic [31:0]       min_exp_ff, min_exp_in;
   logic [SLOT_W-1:0] target_ff, target_in;
   logic              evict_ff, evict_in;
   rsp_type           rsp_ff, rsp_in;

   // Session memory and its per-slot valid bits.
   entry_type         mem [DEPTH];
   entry_type         rdata_ff;
   logic              rd_valid_ff;
   logic [DEPTH-1:0]  valid_ff;

   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic              wr_en;
   entry_type         wr_data;
   entry_type         entry;
   scan_type          scan;
   logic              victim_take;

   assign rd_addr = {req_ff.table_select, cnt_ff};
   assign wr_addr = {req_ff.table_select, target_ff};

   assign wr_data.remote_ip   = req_ff.remote_ip;
   assign wr_data.remote_port = req_ff.remote_port;
   assign wr_data.local_ip    = req_ff.local_ip;
   assign wr_data.local_port  = req_ff.local_port;
   assign wr_data.public_ip   = req_ff.public_ip;
   assign wr_data.public_port = req_ff.public_port;
   assign wr_data.expiry      = req_ff.expire_time;

   // Write one slot, read one slot; read data is registered.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // A slot never written since reset reads as all zero.
   assign entry = rd_valid_ff ? rdata_ff : '0;

   nat_scan_unit u_scan (
      .entry      (entry),
      .key        (req_ff),
      .min_expiry (min_exp_ff),
      .result     (scan)
   );

   // Slot 0 seeds the minimum; later slots replace it only when strictly less.
   assign victim_take = (chk_idx_ff == FIRST_SLOT) || scan.less;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = (state_ff == ST_RESP);
   assign rsp_chan.data  = rsp_ff;

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      cnt_in        = cnt_ff;
      issue_done_in = issue_done_ff;
      chk_valid_in  = chk_valid_ff;
      chk_idx_in    = chk_idx_ff;
      victim_in     = victim_ff;
      min_exp_in    = min_exp_ff;
      target_in     = target_ff;
      evict_in      = evict_ff;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               req_in        = req_chan.data;
               cnt_in        = FIRST_SLOT;
               issue_done_in = 1'b0;
               chk_valid_in  = 1'b0;
               if (req_chan.data.opcode inside {OP_OUTBOUND, OP_INBOUND, OP_INSERT}) begin
                  state_in = ST_SCAN;
               end else begin
                  // Unknown opcode: answer with an all-zero result.
                  rsp_in   = '0;
                  state_in = ST_RESP;
               end
            end
         end

         ST_SCAN: begin
            // Issue the next slot read while checking the one read last cycle.
            chk_valid_in = !issue_done_ff;
            chk_idx_in   = cnt_ff;
            if (!issue_done_ff) begin
               if (cnt_ff == LAST_SLOT) begin
                  issue_done_in = 1'b1;
               end else begin
                  cnt_in = cnt_ff + SLOT_W'(1);
               end
            end

            if (chk_valid_ff) begin
               if (req_ff.opcode == OP_INSERT) begin
                  if (scan.empty) begin
                     target_in    = chk_idx_ff;
                     evict_in     = 1'b0;
                     chk_valid_in = 1'b0;
                     state_in     = ST_WRITE;
                  end else begin
                     if (victim_take) begin
                        victim_in  = chk_idx_ff;
                        min_exp_in = entry.expiry;
                     end
                     if (chk_idx_ff == LAST_SLOT) begin
                        target_in    = victim_take ? chk_idx_ff : victim_ff;
                        evict_in     = 1'b1;
                        chk_valid_in = 1'b0;
                        state_in     = ST_WRITE;
                     end
                  end
               end else if (scan.hit) begin
                  rsp_in.found             = 1'b1;
                  rsp_in.slot_index        = slot_to_index(chk_idx_ff);
                  rsp_in.evicted           = 1'b0;
                  rsp_in.entry_remote_ip   = entry.remote_ip;
                  rsp_in.entry_remote_port = entry.remote_port;
                  rsp_in.entry_local_ip    = entry.local_ip;
                  rsp_in.entry_local_port  = entry.local_port;
                  rsp_in.entry_public_ip   = entry.public_ip;
                  rsp_in.entry_public_port = entry.public_port;
                  rsp_in.entry_expiry      = entry.expiry;
                  chk_valid_in             = 1'b0;
                  state_in                 = ST_RESP;
               end else if (chk_idx_ff == LAST_SLOT) begin
                  // Miss: all-zero result.
                  rsp_in       = '0;
                  chk_valid_in = 1'b0;
                  state_in     = ST_RESP;
               end
            end
         end

         ST_WRITE: begin
            // Commit the insert and echo the slot as written.
            wr_en                    = 1'b1;
            rsp_in.found             = 1'b1;
            rsp_in.slot_index        = slot_to_index(target_ff);
            rsp_in.evicted           = evict_ff;
            rsp_in.entry_remote_ip   = wr_data.remote_ip;
            rsp_in.entry_remote_port = wr_data.remote_port;
            rsp_in.entry_local_ip    = wr_data.local_ip;
            rsp_in.entry_local_port  = wr_data.local_port;
            rsp_in.entry_public_ip   = wr_data.public_ip;
            rsp_in.entry_public_port = wr_data.public_port;
            rsp_in.entry_expiry      = wr_data.expiry;
            state_in                 = ST_RESP;
         end

         ST_RESP: begin
            // Hold the result until the downstream transfer.
            if (rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issue_done_ff <= 1'b0;
         chk_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issue_done_ff <= issue_done_in;
         chk_valid_ff  <= chk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      cnt_ff     <= cnt_in;
      chk_idx_ff <= chk_idx_in;
      victim_ff  <= victim_in;
      min_exp_ff <= min_exp_in;
      target_ff  <= target_in;
      evict_ff   <= evict_in;
      rsp_ff     <= rsp_in;
   end

endmodule

FILE: design/nat_chk.sv
// Port-level checker for the NAT session table, bound to the top level.
module nat_chk import nat_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A stalled result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // One request at a time: busy right after a request transfer.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // A miss carries a zero slot, no eviction, and a zero remote address and expiry.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |->
         rsp_data.slot_index == '0 && !rsp_data.evicted &&
         rsp_data.entry_remote_ip == '0 && rsp_data.entry_expiry == '0)
      else $error("miss result not cleared");

   // An eviction only comes with a completed insert.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.evicted |-> rsp_data.found)
      else $error("eviction without found");

endmodule

bind nat_session_table nat_chk u_nat_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);

FILE: sim/tb_nat_session_table.sv
// Self-checking testbench for the NAT session table: directed and random ops.
`timescale 1ns / 1ps

module tb_nat_session_table;
   import nat_pkg::*;

   // Opcode three has no function; the block must answer it with an all-zero result.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int RANDOM_OPS     = 1200;
   localparam int PHASE_LEN      = 100;   // accepted ops per idling phase
   localparam int HOLD_OFF_AT    = 600;   // accepted ops before the long receiver stall
   localparam int HOLD_OFF_LEN   = 400;
   localparam int WATCHDOG_LIMIT = 4000;  // quiet cycles before the watchdog ends the run
   localparam int DRAIN_CYCLES   = 2 * TABLE_ENTRIES;

   logic clock = 1'b0;
   logic reset;

   nat_req_if req_chan ();
   nat_rsp_if rsp_chan ();

   nat_session_table dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #10 clock = ~clock;

   // Shadow copy of both tables: TCP in the lower half, UDP in the upper half.
   entry_type session_mem [DEPTH];

   req_type   nat_op_q [$];          // ops waiting to be offered
   rsp_type   nat_result_q [$];      // predicted results, oldest first
   req_type   session_key_pool [$];  // key sets already inserted, for hitting lookups

   int ops_accepted   = 0;
   int mismatch_count = 0;
   int lookup_hits    = 0;
   int lookup_misses  = 0;
   int inserts        = 0;
   int evictions      = 0;
   int unused_ops     = 0;
   int quiet_cycles   = 0;
   int hold_left      = 0;
   bit hold_done      = 1'b0;
   int phase;

   // Copy a stored slot into the entry fields of a result.
   function automatic rsp_type load_entry(rsp_type r, entry_type e);
      r.entry_remote_ip   = e.remote_ip;
      r.entry_remote_port = e.remote_port;
      r.entry_local_ip    = e.local_ip;
      r.entry_local_port  = e.local_port;
      r.entry_public_ip   = e.public_ip;
      r.entry_public_port = e.public_port;
      r.entry_expiry      = e.expiry;
      return r;
   endfunction

   // Apply one op to the shadow tables and return the result the block must give.
   function automatic rsp_type apply_session_op(req_type op);
      rsp_type   r;
      entry_type e;
      int        base;
      int        i;
      int        victim;
      int        target;
      bit        hit;
      bit        empty;
      r      = '0;
      base   = op.table_select ? TABLE_ENTRIES : 0;
      hit    = 1'b0;
      empty  = 1'b0;
      victim = 0;
      target = 0;
      case (op.opcode)
         OP_OUTBOUND, OP_INBOUND: begin
            // Scan from slot 0; an all-zero slot can match zero keys.
            for (i = 0; i < TABLE_ENTRIES && !hit; i++) begin
               e   = session_mem[base + i];
               hit = e.remote_ip == op.remote_ip && e.remote_port == op.remote_port;
               if (op.opcode == OP_OUTBOUND) begin
                  hit = hit && e.local_ip == op.local_ip && e.local_port == op.local_port;
               end else begin
                  hit = hit && e.public_ip == op.public_ip && e.public_port == op.public_port;
               end
               if (hit) begin
                  r.found      = 1'b1;
                  r.slot_index = SLOT_INDEX_W'(i);
                  r = load_entry(r, e);
               end
            end
         end
         OP_INSERT: begin
            // Stop at the first zero remote address; otherwise track the first
            // slot holding the smallest expiry.
            for (i = 0; i < TABLE_ENTRIES && !empty; i++) begin
               if (session_mem[base + i].remote_ip == '0) begin
                  target = i;
                  empty  = 1'b1;
               end else if (session_mem[base + i].expiry < session_mem[base + victim].expiry) begin
                  victim = i;
               end
            end
            if (!empty) begin
               target = victim;
            end
            session_mem[base + target] = '{op.remote_ip, op.remote_port, op.local_ip,
                                           op.local_port, op.public_ip, op.public_port,
                                           op.expire_time};
            r.found      = 1'b1;
            r.slot_index = SLOT_INDEX_W'(target);
            r.evicted    = !empty;
            r = load_entry(r, session_mem[base + target]);
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic req_type make_op(logic [1:0] opc, logic tsel,
                                       logic [31:0] rip, logic [15:0] rpt,
                                       logic [31:0] lip, logic [15:0] lpt,
                                       logic [31:0] pip, logic [15:0] ppt,
                                       logic [31:0] expiry);
      req_type op;
      op.opcode       = opc;
      op.table_select = tsel;
      op.remote_ip    = rip;
      op.remote_port  = rpt;
      op.local_ip     = lip;
      op.local_port   = lpt;
      op.public_ip    = pip;
      op.public_port  = ppt;
      op.expire_time  = expiry;
      return op;
   endfunction

   // Mostly random words, with zero and all-ones showing up now and then.
   function automatic logic [31:0] pick_word();
      int sel;
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
         return '0;
      end else if (sel == 1) begin
         return '1;
      end
      return $urandom;
   endfunction

   // Build one random op: inserts that fill and then churn the tables, lookups
   // mostly aimed at inserted keys (some of them corrupted), and a few unused opcodes.
   function automatic req_type make_random_op();
      req_type op;
      req_type src;
      int      pick;
      op = make_op(OP_OUTBOUND, 1'($urandom), pick_word(), 16'(pick_word()), pick_word(),
                   16'(pick_word()), pick_word(), 16'(pick_word()), pick_word());
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         op.opcode = OP_INSERT;
         // Reuse a key set now and then so lookups face duplicate entries.
         if (session_key_pool.size() != 0 && $urandom_range(0, 9) == 0) begin
            src = session_key_pool[$urandom_range(0, session_key_pool.size() - 1)];
            op.table_select = src.table_select;
            op.remote_ip    = src.remote_ip;
            op.remote_port  = src.remote_port;
            op.local_ip     = src.local_ip;
            op.local_port   = src.local_port;
            op.public_ip    = src.public_ip;
            op.public_port  = src.public_port;
         end
         // Narrow expiries produce ties in the eviction search.
         if ($urandom_range(0, 1) == 0) begin
            op.expire_time = $urandom_range(0, 7);
         end
         if (op.remote_ip != '0) begin
            session_key_pool.push_back(op);
            if (session_key_pool.size() > 256) begin
               void'(session_key_pool.pop_front());
            end
         end
      end else if (pick < 97) begin
         op.opcode = (pick < 68) ? OP_OUTBOUND : OP_INBOUND;
         if (session_key_pool.size() != 0 && $urandom_range(0, 4) != 0) begin
            src = session_key_pool[$urandom_range(0, session_key_pool.size() - 1)];
            op.table_select = src.table_select;
            op.remote_ip    = src.remote_ip;
            op.remote_port  = src.remote_port;
            op.local_ip     = src.local_ip;
            op.local_port   = src.local_port;
            op.public_ip    = src.public_ip;
            op.public_port  = src.public_port;
            // Now and then corrupt one key bit or the table select to force near misses.
            case ($urandom_range(0, 9))
               0: op.table_select = ~op.table_select;
               1: op.remote_port  = op.remote_port ^ (16'h1 << $urandom_range(0, 15));
               2: op.local_ip     = op.local_ip ^ (32'h1 << $urandom_range(0, 31));
               3: op.public_port  = op.public_port ^ (16'h1 << $urandom_range(0, 15));
               default: ;
            endcase
         end
      end else begin
         op.opcode = OP_UNUSED;
      end
      return op;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_result(rsp_type got);
      rsp_type want;
      if (nat_result_q.size() == 0) begin
         $display("%0t: result with nothing expected, expected none, got %h", $time, got);
         mismatch_count++;
         return;
      end
      want = nat_result_q.pop_front();
      check_field("found",             want.found,             got.found);
      check_field("slot_index",        want.slot_index,        got.slot_index);
      check_field("evicted",           want.evicted,           got.evicted);
      check_field("entry_remote_ip",   want.entry_remote_ip,   got.entry_remote_ip);
      check_field("entry_remote_port", want.entry_remote_port, got.entry_remote_port);
      check_field("entry_local_ip",    want.entry_local_ip,    got.entry_local_ip);
      check_field("entry_local_port",  want.entry_local_port,  got.entry_local_port);
      check_field("entry_public_ip",   want.entry_public_ip,   got.entry_public_ip);
      check_field("entry_public_port", want.entry_public_port, got.entry_public_port);
      check_field("entry_expiry",      want.entry_expiry,      got.entry_expiry);
   endtask

   // Idling phases rotate with progress: none, sender gaps, receiver stalls, both.
   assign phase = (ops_accepted / PHASE_LEN) % 4;

   // Request driver: predict on each transfer, then offer the next op unless idling.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            rsp_type r;
            r = apply_session_op(req_chan.data);
            nat_result_q.push_back(r);
            ops_accepted++;
            case (req_chan.data.opcode)
               OP_OUTBOUND, OP_INBOUND: begin
                  if (r.found) begin
                     lookup_hits++;
                  end else begin
                     lookup_misses++;
                  end
               end
               OP_INSERT: begin
                  inserts++;
                  if (r.evicted) begin
                     evictions++;
                  end
               end
               default: unused_ops++;
            endcase
         end
         // Hold the current op until it transfers; only then pick the next one.
         if (!req_chan.valid || req_chan.ready) begin
            if (nat_op_q.size() != 0 &&
                !((phase == 1 && $urandom_range(0, 99) < 61) ||
                  (phase == 3 && $urandom_range(0, 99) < 24))) begin
               req_chan.valid <= 1'b1;
               req_chan.data  <= nat_op_q.pop_front();
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: check each transfer, then decide ready for the next edge.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            check_result(rsp_chan.data);
         end
         // Stall once for a long stretch so the block backs up into its input.
         if (!hold_done && ops_accepted >= HOLD_OFF_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_OFF_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
         end
         rsp_chan.ready <= (hold_left == 0) &&
                           !((phase == 2 && $urandom_range(0, 99) < 61) ||
                             (phase == 3 && $urandom_range(0, 99) < 24));
      end
   end

   // Watchdog: end the run if no transfer happens on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_type ones_op;
      req_type zero_remote_op;
      int      n;

      reset = 1'b1;
      for (n = 0; n < DEPTH; n++) begin
         session_mem[n] = '0;
      end

      ones_op        = make_op(OP_INSERT, 1'b0, '1, '1, '1, '1, '1, '1, '1);
      zero_remote_op = make_op(OP_INSERT, 1'b0, '0, 16'h8001, 32'h1234_5678, 16'h00FF,
                               32'hC0A8_0001, 16'h7FFF, 32'h0000_1000);

      // Zero keys hit the cleared slot 0; all-ones keys miss the empty UDP table.
      nat_op_q.push_back(make_op(OP_OUTBOUND, 1'b0, '0, '0, '0, '0, '0, '0, '0));
      nat_op_q.push_back(make_op(OP_INBOUND, 1'b1, '1, '1, '1, '1, '1, '1, '1));
      nat_op_q.push_back(ones_op);
      // A zero remote address is written but leaves the slot free for the next insert.
      nat_op_q.push_back(zero_remote_op);
      nat_op_q.push_back(make_op(OP_OUTBOUND, 1'b0, '0, 16'h8001, 32'h1234_5678, 16'h00FF,
                                 '0, '0, '0));
      nat_op_q.push_back(make_op(OP_INSERT, 1'b0, 32'h0A00_0001, 16'h0050, 32'h0A00_0002,
                                 16'h1F90, 32'hCB00_7101, 16'h4000, '0));
      nat_op_q.push_back(make_op(OP_OUTBOUND, 1'b0, '1, '1, '1, '1, '0, '0, '0));
      nat_op_q.push_back(make_op(OP_INBOUND, 1'b0, '1, '1, '0, '0, '1, '1, '0));
      nat_op_q.push_back(make_op(OP_OUTBOUND, 1'b0, '1, '1, '1, 16'hFFFE, '0, '0, '0));
      nat_op_q.push_back(make_op(OP_INBOUND, 1'b1, '1, '1, '0, '0, '1, '1, '0));
      nat_op_q.push_back(make_op(OP_INSERT, 1'b1, '1, '1, '1, '1, '1, '1, '0));
      // Duplicate keys in TCP: lookups must still report the first slot.
      nat_op_q.push_back(make_op(OP_INSERT, 1'b0, '1, '1, '1, '1, '1, '1, 32'd5));
      nat_op_q.push_back(make_op(OP_OUTBOUND, 1'b0, '1, '1, '1, '1, '0, '0, '0));
      nat_op_q.push_back(make_op(OP_INBOUND, 1'b1, '1, '1, '0, '0, '1, '1, '0));
      nat_op_q.push_back(make_op(OP_UNUSED, 1'b1, '1, '1, '1, '1, '1, '1, '1));
      nat_op_q.push_back(make_op(OP_UNUSED, 1'b0, '0, '0, '0, '0, '0, '0, '0));
      // Zero keys in UDP skip the written slot 0 and hit the cleared slot 1.
      nat_op_q.push_back(make_op(OP_INBOUND, 1'b1, '0, '0, '0, '0, '0, '0, '0));
      session_key_pool.push_back(ones_op);

      for (n = 0; n < RANDOM_OPS; n++) begin
         nat_op_q.push_back(make_random_op());
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Drain: every op offered and transferred, every result back.
      while (nat_op_q.size() != 0 || req_chan.valid || nat_result_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d ops: %0d lookup hits, %0d lookup misses, %0d unused opcodes",
               ops_accepted, lookup_hits, lookup_misses, unused_ops);
      $display("Inserts %0d with %0d evictions, %0d field mismatches",
               inserts, evictions, mismatch_count);
      if (mismatch_count == 0 && nat_result_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
